/* rtl/bsenc_pkg.sv */
// Shared types, constants and helper functions of the backslash escape encoder.
package bsenc_pkg;

  // Character width limits and default.
  localparam int CHAR_BITS_DEF = 8;
  localparam int CHAR_BITS_MAX = 32;

  // Depth of the queue between the classifier and the serializer.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DQ_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_QUOTES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_NON_ASCII = 2'd2;

  // Character codes used by the encoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [CHAR_BITS_MAX-1:0] PRINT_LOW  = 32'd32;
  localparam logic [CHAR_BITS_MAX-1:0] PRINT_HIGH = 32'd126;

  // Hex digit counts of the escape forms.
  localparam logic [3:0] NDIG_2 = 4'd2;
  localparam logic [3:0] NDIG_4 = 4'd4;
  localparam logic [3:0] NDIG_8 = 4'd8;

  typedef enum logic [1:0] {
    JOB_PLAIN,
    JOB_PAIR,
    JOB_HEX
  } job_kind_t;

  // One classified character, ready to be serialized.
  typedef struct packed {
    logic                     open_q;
    logic                     close_q;
    logic [7:0]               quote;
    job_kind_t                kind;
    logic [7:0]               pair_char;
    logic [3:0]               ndig;
    logic [CHAR_BITS_MAX-1:0] value;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) res = CH_ZERO + {4'd0, nib};
    else             res = 8'h57 + {4'd0, nib};
    return res;
  endfunction

  function automatic logic is_hex_char(input logic [CHAR_BITS_MAX-1:0] c);
    return (c >= 32'h30 && c <= 32'h39) || (c >= 32'h61 && c <= 32'h66) ||
           (c >= 32'h41 && c <= 32'h46);
  endfunction

endpackage

/* rtl/bsenc_if.sv */
// Valid/ready channel interfaces for the input characters and the escaped output.
interface bsenc_in_if #(
  parameter int CHAR_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] in_char;
  logic                 first_char;
  logic                 last_char;

  modport source (output valid, output in_char, output first_char, output last_char,
                  input ready);
  modport sink   (input valid, input in_char, input first_char, input last_char,
                  output ready);
endinterface

interface bsenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

/* rtl/bsenc_front.sv */
// Front end: configuration registers, character classification and hex-chain state.
module bsenc_front
  import bsenc_pkg::*;
#(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_BITS-1:0] in_char,
  input  logic                 first_char,
  input  logic                 last_char,
  input  logic                 q_full,
  output logic                 push,
  output job_t                 job
);

  logic dq_mode_r, add_quotes_r, esc_na_r, prev_hex_r;
  logic prev_hex_nxt;
  logic [CHAR_BITS_MAX-1:0] cx;
  logic [7:0] pair_c;
  logic prev_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_mode_r    <= 1'b1;
      add_quotes_r <= 1'b0;
      esc_na_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DQ_MODE:       dq_mode_r    <= cfg_wdata;
        REG_ADD_QUOTES:    add_quotes_r <= cfg_wdata;
        REG_ESC_NON_ASCII: esc_na_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign cx       = CHAR_BITS_MAX'(in_char);
  assign prev_eff = first_char ? 1'b0 : prev_hex_r;

  always_comb begin
    case (cx)
      32'h5C:  pair_c = CH_BSLASH;
      32'h22:  pair_c = dq_mode_r ? CH_DQUOTE : 8'h00;
      32'h27:  pair_c = dq_mode_r ? 8'h00 : CH_SQUOTE;
      32'h00:  pair_c = CH_ZERO;
      32'h0A:  pair_c = CH_N;
      32'h0D:  pair_c = CH_R;
      32'h08:  pair_c = CH_B;
      32'h0C:  pair_c = CH_F;
      32'h07:  pair_c = CH_A;
      32'h0B:  pair_c = CH_V;
      default: pair_c = 8'h00;
    endcase
  end

  // The eight-digit form needs a full 32-bit character, the four-digit form at least 16 bits;
  // narrower characters always take two digits.
  always_comb begin
    job.open_q    = first_char && add_quotes_r;
    job.close_q   = last_char && add_quotes_r;
    job.quote     = dq_mode_r ? CH_DQUOTE : CH_SQUOTE;
    job.pair_char = pair_c;
    job.value     = cx;
    job.ndig      = NDIG_2;
    job.kind      = JOB_PLAIN;
    prev_hex_nxt  = 1'b0;
    if (pair_c != 8'h00) begin
      job.kind = JOB_PAIR;
    end else if (esc_na_r && (cx < PRINT_LOW || cx > PRINT_HIGH)) begin
      job.kind     = JOB_HEX;
      prev_hex_nxt = 1'b1;
      if (CHAR_BITS >= 32 && cx[31:16] != 16'd0)     job.ndig = NDIG_8;
      else if (CHAR_BITS >= 16 && cx[31:8] != 24'd0) job.ndig = NDIG_4;
    end else if (prev_eff && is_hex_char(cx)) begin
      job.kind     = JOB_HEX;
      prev_hex_nxt = 1'b1;
    end
    if (last_char) prev_hex_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) prev_hex_r <= 1'b0;
    else if (push) prev_hex_r <= prev_hex_nxt;
  end

endmodule

/* rtl/bsenc_fifo.sv */
// Short queue of classified characters between the front end and the serializer.
module bsenc_fifo
  import bsenc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

/* rtl/bsenc_back.sv */
// Back end: emits each classified character's run one character a cycle, unless stalled.
module bsenc_back
  import bsenc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  job_t job,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_char,
  output logic run_last
);

  logic [3:0] pos_r, pos_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r, char_nxt;
  logic       run_last_r;
  logic [3:0] body_len, total, b, d;
  logic [3:0] nib;
  logic       emit, is_last;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign run_last  = run_last_r;

  assign emit    = q_valid && (!out_valid_r || out_ready);
  assign total   = 4'(job.open_q) + body_len + 4'(job.close_q);
  assign is_last = (pos_r == total - 4'd1);
  assign pop     = emit && is_last;
  assign b       = pos_r - 4'(job.open_q);
  assign d       = job.ndig + 4'd1 - b;
  assign nib     = 4'(job.value >> {d[2:0], 2'b00});
  assign pos_nxt = is_last ? 4'd0 : pos_r + 4'd1;

  always_comb begin
    case (job.kind)
      JOB_PLAIN: body_len = 4'd1;
      JOB_PAIR:  body_len = 4'd2;
      JOB_HEX:   body_len = 4'd2 + job.ndig;
      default:   body_len = 4'd1;
    endcase
  end

  always_comb begin
    if (job.open_q && pos_r == 4'd0) begin
      char_nxt = job.quote;
    end else if (b == body_len) begin
      char_nxt = job.quote;
    end else begin
      case (job.kind)
        JOB_PAIR: char_nxt = (b == 4'd0) ? CH_BSLASH : job.pair_char;
        JOB_HEX: begin
          if (b == 4'd0)      char_nxt = CH_BSLASH;
          else if (b == 4'd1) char_nxt = CH_X;
          else                char_nxt = hex_digit(nib);
        end
        default: char_nxt = job.value[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= char_nxt;
      run_last_r <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_pos_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> pos_r == 4'd0)
    else $error("serializer position nonzero with empty queue");
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> pos_r < total)
    else $error("serializer position beyond run length");
  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> pos_r == 4'd0)
    else $error("serializer did not restart after finishing a run");
  a_last_marks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> run_last_r == $past(pop))
    else $error("run_last does not match the end of a run");
`endif

endmodule

/* rtl/backslash_escape_encoder_unit.sv */
// Top level of the backslash escape encoder: front end, queue and output serializer.
//
// The encoder takes one character per input transaction and returns its C-style escaped
// form as a run of 1 to 12 output transactions; run_last marks the final character of each
// run. A plain character gives one output character, a named escape two, a hex escape
// four, six or ten, plus one for an opening and one for a closing quote when quoting is
// on. The serializer emits one character per clock while the receiver takes them, so a
// stream of unquoted plain characters moves at one per clock while ready stays high.
// An accepted transaction is classified in the same cycle and written to a two-entry queue;
// its first output character then passes from the queue head into the output register
// before it shows on the output. The queue lets input be taken while an output
// character waits to be taken. Configuration writes take effect for the next input
// transaction and are expected only while the block is idle. CHAR_BITS sets the input
// character width (8 to 32); wider values may produce four- or eight-digit hex escapes.
module backslash_escape_encoder_unit
  import bsenc_pkg::*;
#(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  bsenc_in_if.sink             in_ch,
  bsenc_out_if.source          out_ch
);

  // Handshake and payload between the three parts.
  job_t job_in, job_head;
  logic push, pop, q_full, q_valid;

  // Classifier: owns the configuration registers and the hex-chain flag.
  bsenc_front #(
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_char    (in_ch.in_char),
    .first_char (in_ch.first_char),
    .last_char  (in_ch.last_char),
    .q_full     (q_full),
    .push       (push),
    .job        (job_in)
  );

  // Decouples classification from serialization so each side stalls on its own.
  bsenc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (job_in),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rdata     (job_head)
  );

  // Serializer: walks the run of the queue head, one output character per transaction.
  bsenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .job       (job_head),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .run_last  (out_ch.run_last)
  );

endmodule

/* verif/backslash_escape_encoder_unit_test.sv */
// Self-checking testbench of the backslash escape encoder with a predictor and random traffic.
module backslash_escape_encoder_unit_test;
  import bsenc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_BITS   = CHAR_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int SEG_ITEMS   = 18;

  // Register index past the last configuration register.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // Control codes with a named two-character escape, plus tab, DEL and 0xFF, which have none.
  localparam logic [7:0] C_NUL = 8'h00;
  localparam logic [7:0] C_BEL = 8'h07;
  localparam logic [7:0] C_BS  = 8'h08;
  localparam logic [7:0] C_TAB = 8'h09;
  localparam logic [7:0] C_LF  = 8'h0A;
  localparam logic [7:0] C_VT  = 8'h0B;
  localparam logic [7:0] C_FF  = 8'h0C;
  localparam logic [7:0] C_CR  = 8'h0D;
  localparam logic [7:0] C_DEL = 8'h7F;
  localparam logic [7:0] C_TOP = 8'hFF;
  // Marker for "this character has no named escape".
  localparam logic [7:0] NO_PAIR = 8'h00;

  // One input transaction waiting to be offered to the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } src_item_t;

  // One escaped character that the block is expected to return.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_char_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic cfg_wdata;

  bsenc_in_if #(.CHAR_BITS(CHAR_BITS)) in_ch ();
  bsenc_out_if out_ch ();

  backslash_escape_encoder_unit #(.CHAR_BITS(CHAR_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  src_item_t pending_items[$];
  esc_char_t expected_chars[$];

  // Predictor copy of the configuration registers and of the escape state.
  logic dq_mode;
  logic add_quotes;
  logic esc_non_ascii;
  logic prev_hex;

  // Scratch run of escaped characters built for one input transaction.
  logic [7:0] run_buf [12];
  int run_len;

  int src_idle_pct;
  int sink_idle_pct;
  logic hold_go;
  logic hold_off;
  int n_errors;
  int n_in;
  int n_out;
  int cycle_count;

  // Free-running clock with every block input at a known value from time zero.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DQ_MODE;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_char = '0;
    in_ch.first_char = 1'b0;
    in_ch.last_char = 1'b0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void put_run(input logic [7:0] ch);
    run_buf[run_len] = ch;
    run_len++;
  endfunction

  function automatic logic [7:0] hex_nibble(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + {4'd0, nib};
    return "a" + {4'd0, nib} - 8'd10;
  endfunction

  // With an 8-bit character only the two-digit form of the hex escape can occur.
  function automatic void put_hex2(input logic [7:0] c);
    put_run(CH_BSLASH);
    put_run(CH_X);
    put_run(hex_nibble(c[7:4]));
    put_run(hex_nibble(c[3:0]));
  endfunction

  // Works out the escaped run for one accepted character and queues it, marking the
  // final character of the run. The escape state is updated as the block would.
  function automatic void predict_escape(input logic [7:0] c, input logic first,
                                         input logic last);
    logic [7:0] quote;
    logic [7:0] pair;
    logic       hex_digit_char;
    quote = dq_mode ? CH_DQUOTE : CH_SQUOTE;
    run_len = 0;
    if (first) begin
      prev_hex = 1'b0;
      if (add_quotes) put_run(quote);
    end
    case (c)
      CH_BSLASH: pair = CH_BSLASH;
      CH_DQUOTE: pair = dq_mode ? CH_DQUOTE : NO_PAIR;
      CH_SQUOTE: pair = dq_mode ? NO_PAIR : CH_SQUOTE;
      C_NUL:     pair = CH_ZERO;
      C_LF:      pair = CH_N;
      C_CR:      pair = CH_R;
      C_BS:      pair = CH_B;
      C_FF:      pair = CH_F;
      C_BEL:     pair = CH_A;
      C_VT:      pair = CH_V;
      default:   pair = NO_PAIR;
    endcase
    hex_digit_char = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                     (c >= "A" && c <= "F");
    if (pair != NO_PAIR) begin
      put_run(CH_BSLASH);
      put_run(pair);
      prev_hex = 1'b0;
    end else if (esc_non_ascii && (c < PRINT_LOW || c > PRINT_HIGH)) begin
      put_hex2(c);
      prev_hex = 1'b1;
    end else if (prev_hex && hex_digit_char) begin
      // A hex digit right after a hex escape would merge with it, so it is escaped too,
      // and the state stays set so that a whole run of digits is escaped.
      put_hex2(c);
    end else begin
      put_run(c);
      prev_hex = 1'b0;
    end
    if (last) begin
      if (add_quotes) put_run(quote);
      prev_hex = 1'b0;
    end
    for (int k = 0; k < run_len; k++) begin
      expected_chars.push_back('{ch: run_buf[k], last: (k == run_len - 1)});
    end
  endfunction

  // Input driver. When a transaction is accepted its escaped run is predicted with the
  // configuration in force; the next pending item is then offered unless the sender idles.
  // An offered item stays put while the block holds ready low.
  always @(posedge clk) begin : feed_input
    src_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_escape(in_ch.in_char, in_ch.first_char, in_ch.last_char);
        nxt = pending_items.pop_front();
        n_in++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_items[0];
          in_ch.valid <= 1'b1;
          in_ch.in_char <= nxt.ch;
          in_ch.first_char <= nxt.first;
          in_ch.last_char <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Every accepted output transaction is compared field by field with the
  // oldest expected character; ready is then toggled at random or held low by the hold-off.
  always @(posedge clk) begin : check_output
    esc_char_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (expected_chars.size() == 0) begin
          n_errors++;
          $display("%0t MISMATCH: unexpected output char=%h run_last=%b", $time,
                   out_ch.out_char, out_ch.run_last);
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_char !== want.ch) begin
            n_errors++;
            $display("%0t MISMATCH out_char: expected %h actual %h", $time, want.ch,
                     out_ch.out_char);
          end
          if (out_ch.run_last !== want.last) begin
            n_errors++;
            $display("%0t MISMATCH run_last: expected %b actual %b", $time, want.last,
                     out_ch.run_last);
          end
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Long receiver hold-off, counted here, so that the block fills up and stops taking input
  // while the sender keeps offering characters.
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_char(input logic [7:0] c, input logic first, input logic last);
    pending_items.push_back('{ch: c, first: first, last: last});
  endtask

  // Register write through the configuration port; the predictor copy follows at once,
  // which is safe because writes are only issued while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DQ_MODE:       dq_mode = val;
      REG_ADD_QUOTES:    add_quotes = val;
      REG_ESC_NON_ASCII: esc_non_ascii = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every pending item has been taken and every expected character returned,
  // then idles on further clock edges so the block is surely idle.
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Character mix: printable text, hex digits (to follow hex escapes), the named escapes
  // with tab and both quotes, and the full code range.
  function automatic logic [7:0] pick_char();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 35) return 8'($urandom_range(126, 32));
    if (r < 55) begin
      n = $urandom_range(21);
      if (n < 10) return "0" + 8'(n);
      if (n < 16) return "a" + 8'(n - 10);
      return "A" + 8'(n - 16);
    end
    if (r < 70) begin
      case ($urandom_range(10))
        0: return C_NUL;
        1: return C_BEL;
        2: return C_BS;
        3: return C_TAB;
        4: return C_LF;
        5: return C_VT;
        6: return C_FF;
        7: return C_CR;
        8: return CH_BSLASH;
        9: return CH_DQUOTE;
        default: return CH_SQUOTE;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed strings of one to eight characters; about one item in seven gets
  // random marks, which leaves strings open or starts new ones in the middle.
  task automatic queue_random_strings(input int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        queue_char(pick_char(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        left--;
      end else begin
        len = $urandom_range(8, 1);
        if (len > left) len = left;
        for (int k = 0; k < len; k++) queue_char(pick_char(), k == 0, k == len - 1);
        left -= len;
      end
    end
  endtask

  initial begin
    logic [2:0] setting;
    dq_mode = 1'b1;
    add_quotes = 1'b0;
    esc_non_ascii = 1'b0;
    prev_hex = 1'b0;
    hold_go = 1'b0;
    n_errors = 0;
    n_in = 0;
    n_out = 0;
    cycle_count = 0;
    src_idle_pct = 18;
    sink_idle_pct = 45;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: tab and a high code pass through, the
    // single quote is left alone in double-quote mode.
    queue_char(C_TAB, 1'b1, 1'b0);
    queue_char(CH_DQUOTE, 1'b0, 1'b0);
    queue_char(8'h80, 1'b0, 1'b0);
    queue_char(CH_SQUOTE, 1'b0, 1'b1);
    wait_drained();

    // Directed part with quoting and hex escapes on: every named escape, the printable
    // limits, both ends of the code range, chained hex digits after a hex escape, a
    // one-character string and a string continued without a first mark.
    write_reg(REG_DQ_MODE, 1'b1);
    write_reg(REG_ADD_QUOTES, 1'b1);
    write_reg(REG_ESC_NON_ASCII, 1'b1);
    queue_char(C_NUL, 1'b1, 1'b0);
    queue_char(CH_BSLASH, 1'b0, 1'b0);
    queue_char(CH_DQUOTE, 1'b0, 1'b0);
    queue_char(CH_SQUOTE, 1'b0, 1'b0);
    queue_char(C_LF, 1'b0, 1'b0);
    queue_char(C_CR, 1'b0, 1'b0);
    queue_char(C_BS, 1'b0, 1'b0);
    queue_char(C_FF, 1'b0, 1'b0);
    queue_char(C_BEL, 1'b0, 1'b0);
    queue_char(C_VT, 1'b0, 1'b0);
    queue_char(C_TAB, 1'b0, 1'b0);
    queue_char(8'h1F, 1'b0, 1'b0);
    queue_char("a", 1'b0, 1'b0);
    queue_char("F", 1'b0, 1'b0);
    queue_char("0", 1'b0, 1'b0);
    queue_char("g", 1'b0, 1'b0);
    queue_char(8'h20, 1'b0, 1'b0);
    queue_char(8'h7E, 1'b0, 1'b0);
    queue_char(C_DEL, 1'b0, 1'b1);
    queue_char(C_TOP, 1'b0, 1'b0);
    queue_char("9", 1'b0, 1'b1);
    queue_char("A", 1'b1, 1'b1);
    wait_drained();

    // Random part: all eight register settings in turn. The first three run with a slow
    // receiver, the next three with a slow sender, the last two without idling, and the
    // first of those starts with the long receiver hold-off.
    for (int s = 0; s < 8; s++) begin
      setting = 3'(s);
      if (s == 3) begin
        src_idle_pct = 45;
        sink_idle_pct = 18;
      end else if (s == 6) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      write_reg(REG_DQ_MODE, setting[0]);
      write_reg(REG_ADD_QUOTES, setting[1]);
      write_reg(REG_ESC_NON_ASCII, setting[2]);
      // An index past the last register must leave every setting unchanged.
      if (s == 4) write_reg(REG_NONE, 1'b1);
      if (s == 6) hold_go = 1'b1;
      queue_random_strings(SEG_ITEMS);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (expected_chars.size() != 0) begin
      n_errors++;
      $display("%0t MISMATCH: %0d expected characters never arrived", $time,
               expected_chars.size());
    end
    $display("Run covered %0d input characters and %0d escaped output characters,",
             n_in, n_out);
    $display("over all eight quote and escape settings, with %0d mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* backslash_escape_encoder_unit.f */
rtl/bsenc_pkg.sv
rtl/bsenc_if.sv
rtl/bsenc_front.sv
rtl/bsenc_fifo.sv
rtl/bsenc_back.sv
rtl/backslash_escape_encoder_unit.sv
verif/backslash_escape_encoder_unit_test.sv
